/* hw/rtl/multi_waveform_phase_oscillator_unit_assert.svh */
// Assertion macros used by the oscillator checker
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MWPO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MWPO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mwpo_pkg.sv */
// Types, constants and the sine quarter-wave table of the oscillator
`timescale 1ns / 1ps

package mwpo_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int STEP_W          = 32;
	localparam int SAMPLE_W        = 16;
	localparam int NOISE_W         = 16;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int ALIGN_W         = STEP_W + PHASE_BITS;

	localparam int SINE_N   = 1 << SINE_TABLE_BITS;
	localparam int SINE_Q   = SINE_N / 4;
	localparam int SINE_K_W = SINE_TABLE_BITS - 1;

	localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h80200003;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic [2:0] {
		WAVE_SQUARE   = 3'd0,
		WAVE_SAW      = 3'd1,
		WAVE_TRIANGLE = 3'd2,
		WAVE_NOISE    = 3'd3,
		WAVE_SINE     = 3'd4
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_TYPE   = 1'd0,
		REG_START_PHASE = 1'd1
	} cfg_reg_t;

	// Item handed from the phase stage to the waveform stage
	typedef struct packed {
		logic                  valid;
		logic [PHASE_BITS-1:0] phase;
		logic [NOISE_W-1:0]    noise;
	} acc_stage_t;

	typedef logic [14:0] sine_qtr_t [0:SINE_Q];

	// Place a 32-bit cycle fraction at the top of the accumulator
	function automatic logic [PHASE_BITS-1:0] align_phase(logic [STEP_W-1:0] v);
		logic [ALIGN_W-1:0] wide;
		wide = {v, {PHASE_BITS{1'b0}}};
		return wide[ALIGN_W-1 -: PHASE_BITS];
	endfunction

	// Quarter sine wave in Q0.15 magnitude, Taylor series in Q30
	function automatic sine_qtr_t build_sine_qtr();
		sine_qtr_t          tab;
		logic [63:0]        z;
		logic [63:0]        z2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		int                 k;
		int                 j;
		for (k = 0; k <= SINE_Q; k++) begin
			z    = (TWO_PI_Q30 * 64'(k)) / SINE_N;
			z2   = (z * z) >> 30;
			term = z;
			sum  = signed'(z);
			for (j = 1; j <= 5; j++) begin
				term = (term * z2) >> 30;
				term = term / 64'((2 * j) * (2 * j + 1));
				if (j % 2 == 1)
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			if (sum < 0)
				sum = 0;
			v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
			if (v > 64'sd32767)
				v = 64'sd32767;
			tab[k] = v[14:0];
		end
		return tab;
	endfunction

	localparam sine_qtr_t SINE_QTR = build_sine_qtr();

endpackage

/* hw/rtl/mwpo_if.sv */
// Valid/ready channels for oscillator input and result items
`timescale 1ns / 1ps

interface mwpo_in_if;
	logic                        valid;
	logic                        ready;
	logic [mwpo_pkg::STEP_W-1:0] phase_step;
	logic                        restart;

	modport source (output valid, output phase_step, output restart, input ready);
	modport sink (input valid, input phase_step, input restart, output ready);
endinterface

interface mwpo_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/mwpo_phase_acc.sv */
// Input register, phase accumulator and noise LFSR
`timescale 1ns / 1ps

module mwpo_phase_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	mwpo_in_if.sink                         item_in,
	input  logic [mwpo_pkg::STEP_W-1:0]     start_phase,
	output mwpo_pkg::acc_stage_t            acc,
	input  logic                            acc_ready
);

	logic                                valid_s1;
	logic [mwpo_pkg::STEP_W-1:0]         step_s1;
	logic                                restart_s1;
	logic                                valid_s2;
	logic [mwpo_pkg::PHASE_BITS-1:0]     phase_s2;
	logic [mwpo_pkg::NOISE_W-1:0]        noise_s2;
	logic [mwpo_pkg::PHASE_BITS-1:0]     phase_acc_q;
	logic [31:0]                         lfsr_q;
	logic                                adv_s1;
	logic [mwpo_pkg::PHASE_BITS-1:0]     phase_base;
	logic [mwpo_pkg::PHASE_BITS-1:0]     phase_next;
	logic [31:0]                         lfsr_next;

	// Advance the input stage when the next stage is free or draining
	assign adv_s1        = valid_s1 && (!valid_s2 || acc_ready);
	assign item_in.ready = !valid_s1 || adv_s1;

	// New phase: optional restart, then add the step modulo one cycle
	always_comb begin
		phase_base = restart_s1 ? mwpo_pkg::align_phase(start_phase) : phase_acc_q;
		phase_next = phase_base + mwpo_pkg::align_phase(step_s1);
		lfsr_next  = lfsr_q[0] ? ((lfsr_q >> 1) ^ mwpo_pkg::LFSR_TAPS) : (lfsr_q >> 1);
	end

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			step_s1    <= item_in.phase_step;
			restart_s1 <= item_in.restart;
		end
	end

	// Update oscillator state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			lfsr_q      <= mwpo_pkg::LFSR_SEED;
			valid_s2    <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_acc_q <= phase_next;
				lfsr_q      <= lfsr_next;
				valid_s2    <= 1'b1;
			end else if (acc_ready) begin
				valid_s2    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			phase_s2 <= phase_next;
			noise_s2 <= lfsr_next[31 -: mwpo_pkg::NOISE_W];
		end
	end

	assign acc = '{valid: valid_s2, phase: phase_s2, noise: noise_s2};

endmodule

/* hw/rtl/mwpo_wave_gen.sv */
// Waveform shaping from the phase and the result register
`timescale 1ns / 1ps

module mwpo_wave_gen (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mwpo_pkg::acc_stage_t acc,
	output logic                 acc_ready,
	input  logic [2:0]           wave_type,
	mwpo_out_if.source           item_out
);

	localparam int PB = mwpo_pkg::PHASE_BITS;
	localparam int SB = mwpo_pkg::SINE_TABLE_BITS;
	localparam int KW = mwpo_pkg::SINE_K_W;
	localparam logic [KW-1:0] Q_K = KW'(mwpo_pkg::SINE_Q);

	logic                                valid_s3;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] sample_s3;
	logic [15:0]                          t;
	logic [15:0]                          dbl;
	logic [SB-1:0]                        sidx;
	logic [KW-1:0]                        sk;
	logic [14:0]                          smag;
	logic signed [15:0]                   sine_val;
	logic [15:0]                          tri_wave;
	logic                                 sq_high;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] sample_next;

	assign acc_ready = !valid_s3 || item_out.ready;

	// Derive the waveforms from the phase; noise takes the item's LFSR bits
	always_comb begin
		t    = acc.phase[PB-1 -: 16];
		dbl  = {t[14:0], 1'b0};
		sidx = acc.phase[PB-1 -: SB];

		sq_high = acc.phase[PB-1] && (|acc.phase[PB-2:0]);

		// Fold the sine index onto the quarter wave
		sk       = sidx[SB-2] ? (Q_K - {1'b0, sidx[SB-3:0]}) : {1'b0, sidx[SB-3:0]};
		smag     = mwpo_pkg::SINE_QTR[sk];
		sine_val = sidx[SB-1] ? -signed'({1'b0, smag}) : signed'({1'b0, smag});

		// Triangle saturates at the very start of the cycle
		if (t == 16'd0)
			tri_wave = 16'h7FFF;
		else if (t[15])
			tri_wave = dbl ^ 16'h8000;
		else
			tri_wave = 16'h8000 - dbl;

		unique case (wave_type)
			mwpo_pkg::WAVE_SQUARE:   sample_next = sq_high ? 16'sd32767 : -16'sd32767;
			mwpo_pkg::WAVE_SAW:      sample_next = signed'({~t[15], t[14:0]});
			mwpo_pkg::WAVE_TRIANGLE: sample_next = signed'(tri_wave);
			mwpo_pkg::WAVE_NOISE:    sample_next = signed'(acc.noise);
			mwpo_pkg::WAVE_SINE:     sample_next = sine_val;
			default:                 sample_next = '0;
		endcase
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (acc_ready) begin
			valid_s3 <= acc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ready && acc.valid) begin
			sample_s3 <= sample_next;
		end
	end

	assign item_out.valid  = valid_s3;
	assign item_out.sample = sample_s3;

endmodule

/* hw/rtl/multi_waveform_phase_oscillator_unit.sv */
// Multi-waveform phase oscillator: configuration registers and pipeline
//
// Usage:
//   item_in carries a 32-bit phase step (fraction of a cycle) and a restart
//   flag; item_out returns one signed Q1.15 sample per item.
//   The write port (cfg_we, cfg_index, cfg_data) sets the wave type
//   (index 0) and the start phase (index 1); write only while idle.
//   Restart loads the start phase, then the step is added modulo one cycle.
//   The noise generator steps on every item whatever the wave type.
// Pipeline and throughput:
//   Three registers (input, phase accumulator, result) hold an item in
//   that order before its sample shows at item_out. One item is
//   accepted every cycle while results are taken; the phase add that
//   closes the accumulator loop is combinational.
// Reset:
//   Phase clears to zero, the noise register loads its seed, wave type is
//   square and start phase zero; the pipeline empties.
// Stall:
//   A result waits in the output register; the stages behind it keep
//   filling, and item_in.ready drops only once all three are occupied.
`timescale 1ns / 1ps

module multi_waveform_phase_oscillator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	mwpo_in_if.sink                             item_in,
	mwpo_out_if.source                          item_out,
	input  logic                                cfg_we,
	input  logic [mwpo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mwpo_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [2:0]                  wave_type_q;
	logic [mwpo_pkg::STEP_W-1:0] start_phase_q;
	mwpo_pkg::acc_stage_t        acc;
	logic                        acc_ready;

	// Capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q   <= mwpo_pkg::WAVE_SQUARE;
			start_phase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwpo_pkg::REG_WAVE_TYPE:   wave_type_q   <= cfg_data[2:0];
				mwpo_pkg::REG_START_PHASE: start_phase_q <= cfg_data[mwpo_pkg::STEP_W-1:0];
				default:                   start_phase_q <= start_phase_q;
			endcase
		end
	end

	mwpo_phase_acc u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_in     (item_in),
		.start_phase (start_phase_q),
		.acc         (acc),
		.acc_ready   (acc_ready)
	);

	mwpo_wave_gen u_wave (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.acc_ready (acc_ready),
		.wave_type (wave_type_q),
		.item_out  (item_out)
	);

endmodule

/* hw/rtl/mwpo_checker.sv */
// Port-level checks for the oscillator, bound to the top level
`timescale 1ns / 1ps
`include "multi_waveform_phase_oscillator_unit_assert.svh"

module mwpo_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mwpo_pkg::SAMPLE_W-1:0] out_sample,
	input logic                                 cfg_we,
	input logic [mwpo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [mwpo_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [2:0] wave_q;
	logic       new_out;

	// Shadow the wave type from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= mwpo_pkg::WAVE_SQUARE;
		end else if (cfg_we && cfg_index == mwpo_pkg::REG_WAVE_TYPE) begin
			wave_q <= cfg_data[2:0];
		end
	end

	// Result register holds a valid sample (the expression reduces to out_valid)
	assign new_out = out_valid && !in_valid | out_valid;

	// A stalled result holds its value
	`MWPO_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_sample), "result changed while stalled")

	// Input back-pressure only when a result is waiting
	`MWPO_ASSERT_IMP(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready,
		"input stalled with output free")

	// Square wave results take only the two peak values
	`MWPO_ASSERT_IMP(a_square, clk, arst_n,
		new_out && (!$past(out_valid) || $past(out_ready))
			&& $past(wave_q) == 3'(mwpo_pkg::WAVE_SQUARE),
		out_sample == 16'sd32767 || out_sample == -16'sd32767, "square sample off peak")

	// Unused wave codes give silence
	`MWPO_ASSERT_IMP(a_unused, clk, arst_n,
		new_out && (!$past(out_valid) || $past(out_ready))
			&& $past(wave_q) > 3'(mwpo_pkg::WAVE_SINE),
		out_sample == 16'sd0, "unused wave code not silent")

endmodule

bind multi_waveform_phase_oscillator_unit mwpo_checker u_mwpo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item_in.valid),
	.in_ready   (item_in.ready),
	.out_valid  (item_out.valid),
	.out_ready  (item_out.ready),
	.out_sample (item_out.sample),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data)
);

/* sim/testbench.sv */
// Self-checking testbench for the multi-waveform phase oscillator
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_N         = 1 << mwpo_pkg::SINE_TABLE_BITS;
	localparam int LIMIT_CYCLES    = 200000;
	localparam int RAND_PHASES     = 16;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 250;
	localparam int SETTLE_CYCLES   = 16;
	localparam int MAX_PRINTED     = 30;
	localparam int PROBE_COUNT     = 21;

	// Wave codes with no waveform behind them
	localparam logic [2:0] WAVE_UNUSED_A = 3'd5;
	localparam logic [2:0] WAVE_UNUSED_B = 3'd6;
	localparam logic [2:0] WAVE_UNUSED_C = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [2:0]         wave;
		logic [31:0]        start;
		logic [31:0]        step;
		logic               rs;
		bit                 typed;
		logic signed [15:0] sample;
	} probe_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [mwpo_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mwpo_pkg::CFG_DATA_W-1:0] cfg_data;

	mwpo_in_if  in_ch ();
	mwpo_out_if out_ch ();

	multi_waveform_phase_oscillator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (in_ch),
		.item_out  (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state and shadow of the configuration
	logic [31:0]        osc_phase;
	logic [31:0]        noise_reg;
	logic [2:0]         wave_cfg;
	logic [31:0]        start_cfg;
	logic signed [15:0] sine_lut [TABLE_N];

	logic signed [15:0] pending_samples [$];
	logic signed [15:0] oldest_sample;

	idle_mode_t idle_mode = IDLE_NONE;
	int         hold_requests = 0;
	int         holds_started = 0;
	int         hold_left = 0;
	int         faults = 0;
	int         items_sent = 0;
	int         results_seen = 0;
	int         input_stalls = 0;
	int         cycles = 0;
	bit [7:0]   waves_seen = '0;

	// Directed probes: extremes, every wave code, half-cycle edge, wrap, saturation
	probe_t probes [PROBE_COUNT] = '{
		'{mwpo_pkg::WAVE_SQUARE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, -16'sd32767},
		'{mwpo_pkg::WAVE_SQUARE,   32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, -16'sd32767},
		'{mwpo_pkg::WAVE_SQUARE,   32'h0000_0000, 32'h0000_0001, 1'b0, 1'b1, 16'sd32767},
		'{mwpo_pkg::WAVE_SQUARE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, -16'sd32767},
		'{mwpo_pkg::WAVE_SAW,      32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 16'sh8000},
		'{mwpo_pkg::WAVE_SAW,      32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'sd32767},
		'{mwpo_pkg::WAVE_SAW,      32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 16'sh8000},
		'{mwpo_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 16'sd32767},
		'{mwpo_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 16'sh8000},
		'{mwpo_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h4000_0000, 1'b0, 1'b1, 16'sd0},
		'{mwpo_pkg::WAVE_NOISE,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 16'sd0},
		'{mwpo_pkg::WAVE_NOISE,    32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0, 16'sd0},
		'{mwpo_pkg::WAVE_SINE,     32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 16'sd0},
		'{mwpo_pkg::WAVE_SINE,     32'h4000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'sd0},
		'{mwpo_pkg::WAVE_SINE,     32'h4000_0000, 32'h4000_0000, 1'b0, 1'b1, 16'sd0},
		'{mwpo_pkg::WAVE_SINE,     32'h4000_0000, 32'h4000_0000, 1'b0, 1'b0, 16'sd0},
		'{mwpo_pkg::WAVE_SINE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'sd0},
		'{WAVE_UNUSED_A,           32'hFFFF_FFFF, 32'h0000_0005, 1'b0, 1'b1, 16'sd0},
		'{WAVE_UNUSED_B,           32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 16'sd0},
		'{WAVE_UNUSED_C,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'sd0},
		'{mwpo_pkg::WAVE_NOISE,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 16'sd0}
	};

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_fault(input string msg);
		faults++;
		if (faults <= MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// Sine entry from a quarter wave, Taylor series in Q30 with truncated terms
	function automatic logic signed [15:0] sine_entry(input int idx);
		longint unsigned z;
		longint unsigned z2;
		longint unsigned term;
		longint          acc;
		longint          v;
		int              quarter;
		int              k;
		int              n;
		bit              neg;
		quarter = TABLE_N / 4;
		neg = (idx >= 2 * quarter);
		if (idx < quarter)
			k = idx;
		else if (idx < 2 * quarter)
			k = 2 * quarter - idx;
		else if (idx < 3 * quarter)
			k = idx - 2 * quarter;
		else
			k = 4 * quarter - idx;
		z = (longint'(mwpo_pkg::TWO_PI_Q30) * longint'(k)) / TABLE_N;
		z2 = (z * z) >> 30;
		term = z;
		acc = longint'(z);
		for (n = 1; n <= 5; n++) begin
			term = (term * z2) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
		if (v > 64'sd32767)
			v = 64'sd32767;
		if (neg)
			v = -v;
		return v[15:0];
	endfunction

	// Advance phase and noise for one item and return the sample it gives
	function automatic logic signed [15:0] next_sample(input logic [31:0] step, input logic rs);
		int          t;
		int          d;
		int          s;
		if (rs)
			osc_phase = start_cfg;
		osc_phase = osc_phase + step;
		if (noise_reg[0])
			noise_reg = (noise_reg >> 1) ^ mwpo_pkg::LFSR_TAPS;
		else
			noise_reg = noise_reg >> 1;
		t = int'(osc_phase[31:16]);
		case (wave_cfg)
			mwpo_pkg::WAVE_SQUARE: s = (osc_phase > 32'h8000_0000) ? 32767 : -32767;
			mwpo_pkg::WAVE_SAW: s = t - 32768;
			mwpo_pkg::WAVE_TRIANGLE: begin
				d = 65536 - 2 * t;
				if (d < 0)
					d = -d;
				s = d - 32768;
				if (s > 32767)
					s = 32767;
			end
			mwpo_pkg::WAVE_NOISE: s = int'($signed(noise_reg[31:16]));
			mwpo_pkg::WAVE_SINE:
				s = int'(sine_lut[osc_phase[31 -: mwpo_pkg::SINE_TABLE_BITS]]);
			default: s = 0;
		endcase
		return s[15:0];
	endfunction

	function automatic int sender_pct();
		case (idle_mode)
			IDLE_SENDER: return 78;
			IDLE_BOTH: return 12;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 78;
			IDLE_BOTH: return 12;
			default: return 0;
		endcase
	endfunction

	// Offer one item, hold it until taken and log the sample it should give
	task automatic offer_item(input logic [31:0] step, input logic rs, input bit typed,
			input logic signed [15:0] typed_sample);
		logic signed [15:0] want;
		while (sender_pct() != 0 && $urandom_range(0, 99) < sender_pct()) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.phase_step = step;
		in_ch.restart = rs;
		@(posedge clk);
		while (!in_ch.ready) begin
			input_stalls++;
			@(posedge clk);
		end
		want = next_sample(step, rs);
		if (typed)
			want = typed_sample;
		pending_samples = {pending_samples, want};
		waves_seen[wave_cfg] = 1'b1;
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every pending sample has come back
	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input mwpo_pkg::cfg_reg_t idx, input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			mwpo_pkg::REG_WAVE_TYPE: wave_cfg = data[2:0];
			mwpo_pkg::REG_START_PHASE: start_cfg = data;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 65535);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 65535);
			3: return 32'h8000_0000 + $urandom_range(0, 4095) - 2048;
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'h8000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom() >> $urandom_range(0, 24);
		endcase
	endfunction

	// Receiver: random stalls plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_started) begin
				holds_started = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				out_ch.ready = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = !(receiver_pct() != 0 && $urandom_range(0, 99) < receiver_pct());
			end
		end
	end

	// Compare each sample taken with the oldest one pending
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_samples.size() == 0) begin
				report_fault($sformatf("sample %0d with none pending", out_ch.sample));
			end else begin
				oldest_sample = pending_samples.pop_front();
				if (out_ch.sample !== oldest_sample)
					report_fault($sformatf("sample %0d, want %0d (result %0d)",
						out_ch.sample, oldest_sample, results_seen));
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d samples pending.",
			cycles, pending_samples.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Stimulus
	initial begin
		int          p;
		int          i;
		int          n;
		int          r;
		int          run_len;
		logic [31:0] step;
		logic [31:0] start;
		logic        rs;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mwpo_pkg::REG_WAVE_TYPE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.phase_step = '0;
		in_ch.restart = 1'b0;
		osc_phase = '0;
		noise_reg = mwpo_pkg::LFSR_SEED;
		wave_cfg = mwpo_pkg::WAVE_SQUARE;
		start_cfg = '0;
		for (i = 0; i < TABLE_N; i++)
			sine_lut[i] = sine_entry(i);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed probes, registers rewritten only where a probe changes them
		for (i = 0; i < PROBE_COUNT; i++) begin
			if (probes[i].wave != wave_cfg || probes[i].start != start_cfg)
				drain();
			if (probes[i].wave != wave_cfg)
				write_reg(mwpo_pkg::REG_WAVE_TYPE, {29'd0, probes[i].wave});
			if (probes[i].start != start_cfg)
				write_reg(mwpo_pkg::REG_START_PHASE, probes[i].start);
			offer_item(probes[i].step, probes[i].rs, probes[i].typed, probes[i].sample);
		end

		// Random phases: tone runs with random content, some broken by stray steps
		for (p = 0; p < RAND_PHASES; p++) begin
			drain();
			idle_mode = idle_mode_t'(p % 4);
			case (p % 4)
				0: start = 32'h0000_0000;
				1: start = 32'hFFFF_FFFF;
				default: start = $urandom();
			endcase
			write_reg(mwpo_pkg::REG_WAVE_TYPE, 32'((p * 3) % 8));
			write_reg(mwpo_pkg::REG_START_PHASE, start);
			if (p == PRESSURE_PHASE)
				hold_requests++;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				run_len = $urandom_range(1, 24);
				step = pick_step();
				for (r = 0; r < run_len && n < ITEMS_PER_PHASE; r++) begin
					if (r == 0)
						rs = $urandom_range(0, 1);
					else
						rs = ($urandom_range(0, 31) == 0);
					if ($urandom_range(0, 9) == 0)
						offer_item($urandom(), rs, 1'b0, 16'sd0);
					else
						offer_item(step, rs, 1'b0, 16'sd0);
					n++;
				end
			end
		end

		// Let the pipeline empty, then watch for stray results
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_samples.size() != 0)
			report_fault($sformatf("%0d samples never arrived", pending_samples.size()));

		$display("Sent %0d items over %0d wave codes and checked %0d samples; %0d faults.",
			items_sent, $countones(waves_seen), results_seen, faults);
		$display("Input was held back for %0d cycles while results backed up.", input_stalls);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* multi_waveform_phase_oscillator_unit.f */
+incdir+hw/rtl
hw/rtl/mwpo_pkg.sv
hw/rtl/mwpo_if.sv
hw/rtl/mwpo_phase_acc.sv
hw/rtl/mwpo_wave_gen.sv
hw/rtl/multi_waveform_phase_oscillator_unit.sv
hw/rtl/mwpo_checker.sv
sim/testbench.sv
